>>> hw/rtl/launcher_ramped_pwm_sequencer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the launcher PWM sequencer
// Concurrent checks. In synthesis they compile to nothing.
// ---------------------------------------------------------------------------
`ifndef LAUNCHER_RAMPED_PWM_SEQUENCER_DEFINES_SVH
`define LAUNCHER_RAMPED_PWM_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication under reset.
`define RPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rps check failed");

// Next-cycle implication under reset.
`define RPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rps check failed");

`else

`define RPS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/rps_pkg.sv
// ---------------------------------------------------------------------------
// rps_pkg
// Shared widths, constants, codes and helpers of the PWM sequencer.
// ---------------------------------------------------------------------------
package rps_pkg;

    // Widths
    localparam int TICK_W  = 17;
    localparam int CMP_W   = (TICK_W > 17) ? TICK_W : 17;
    localparam int PULSE_W = 11;
    localparam int STEP_W  = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Counter saturation value
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Pulse widths in microseconds
    localparam logic [PULSE_W-1:0] NEUTRAL_US  = 11'd1500;
    localparam logic [PULSE_W-1:0] FULL_FWD_US = 11'd2000;
    localparam logic [PULSE_W-1:0] FULL_REV_US = 11'd1000;

    // Register reset values
    localparam logic [15:0]       SPIN_UP_RST = 16'd30;
    localparam logic [15:0]       SHOOT_RST   = 16'd50;
    localparam logic signed [7:0] FEED_RST    = 8'sd50;
    localparam logic [STEP_W-1:0] RAMP_RST    = 10'd100;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPIN_UP = 8'd0,
        CFG_SHOOT   = 8'd1,
        CFG_FEED    = 8'd2,
        CFG_RAMP    = 8'd3
    } t_cfg_idx;

    // Command codes
    typedef enum logic [3:0] {
        CMD_FLY_ON   = 4'd0,
        CMD_FLY_OFF  = 4'd1,
        CMD_FEED_ON  = 4'd2,
        CMD_FEED_OFF = 4'd3,
        CMD_FEED_REV = 4'd4,
        CMD_SHOOT    = 4'd5,
        CMD_CANCEL   = 4'd6,
        CMD_LED_ON   = 4'd7,
        CMD_LED_OFF  = 4'd8
    } t_cmd;

    // Item kind
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Map a speed percentage to a pulse width, clamped to full range
    function automatic logic [PULSE_W-1:0] speed_to_us(input logic signed [7:0] speed);
        logic signed [12:0] s;
        logic signed [12:0] us;
        s = {{5{speed[7]}}, speed};
        if (s < -13'sd100) begin
            s = -13'sd100;
        end else if (s > 13'sd100) begin
            s = 13'sd100;
        end
        us = 13'sd1500 + (s <<< 2) + s;
        return us[PULSE_W-1:0];
    endfunction

endpackage

>>> hw/rtl/launcher_ramped_pwm_sequencer.sv
// ---------------------------------------------------------------------------
// launcher_ramped_pwm_sequencer: two-channel ramped PWM with auto shoot
// State updates and the result word registers at the accept edge.
// Throughput 1 word per cycle while the result slot is empty or i_out_ready is high.
// Synchronous active-low reset: goals/widths neutral, sequence idle, LED off.
// ---------------------------------------------------------------------------
`include "launcher_ramped_pwm_sequencer_defines.svh"

module launcher_ramped_pwm_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_kind,
    input  logic [3:0]                      i_command,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rps_pkg::PULSE_W-1:0]     o_flywheel_pulse_us,
    output logic [rps_pkg::PULSE_W-1:0]     o_feeder_pulse_us,
    output logic                            o_led_level,
    output logic                            o_auto_busy
);
    import rps_pkg::*;

    // Configuration registers
    logic [15:0]        r_spin_up;
    logic [15:0]        r_shoot;
    logic signed [7:0]  r_feed;
    logic [STEP_W-1:0]  r_ramp;

    // Channel state
    logic [PULSE_W-1:0] r_fly_goal,  n_fly_goal;
    logic [PULSE_W-1:0] r_fly_now,   n_fly_now;
    logic [PULSE_W-1:0] r_feed_goal, n_feed_goal;
    logic [PULSE_W-1:0] r_feed_now,  n_feed_now;
    logic               r_auto_on,   n_auto_on;
    logic [TICK_W-1:0]  r_elapsed,   n_elapsed;
    logic               r_led_on,    n_led_on;

    // Result register
    logic               r_out_valid, n_out_valid;

    logic               w_in_acc;
    logic               w_tick;
    logic [CMP_W-1:0]   w_t;
    logic [CMP_W-1:0]   w_spin;
    logic [CMP_W-1:0]   w_total;
    logic [PULSE_W-1:0] w_fly_ramp;
    logic [PULSE_W-1:0] w_feed_ramp;

    // Handshakes: config always taken; input taken when the result slot frees
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_tick      = w_in_acc && (i_kind == KIND_TICK);

    // Sequence timing compares at a common width
    assign w_t     = CMP_W'(r_elapsed);
    assign w_spin  = CMP_W'(r_spin_up);
    assign w_total = CMP_W'({1'b0, r_spin_up} + {1'b0, r_shoot});

    // Apply a command or the sequence part of a tick
    always_comb begin
        n_fly_goal  = r_fly_goal;
        n_feed_goal = r_feed_goal;
        n_auto_on   = r_auto_on;
        n_elapsed   = r_elapsed;
        n_led_on    = r_led_on;
        if (w_in_acc && (i_kind == KIND_CMD)) begin
            unique case (i_command)
                CMD_FLY_ON:   n_fly_goal  = FULL_FWD_US;
                CMD_FLY_OFF:  n_fly_goal  = NEUTRAL_US;
                CMD_FEED_ON:  n_feed_goal = FULL_FWD_US;
                CMD_FEED_OFF: n_feed_goal = NEUTRAL_US;
                CMD_FEED_REV: n_feed_goal = FULL_REV_US;
                CMD_SHOOT: begin
                    n_auto_on = 1'b1;
                    n_elapsed = '0;
                end
                CMD_CANCEL: begin
                    n_fly_goal  = NEUTRAL_US;
                    n_feed_goal = NEUTRAL_US;
                    n_auto_on   = 1'b0;
                end
                CMD_LED_ON:   n_led_on = 1'b1;
                CMD_LED_OFF:  n_led_on = 1'b0;
                default: ;
            endcase
        end else if (w_tick && r_auto_on) begin
            priority if (r_elapsed == TICK_MAX) begin
                n_fly_goal  = NEUTRAL_US;
                n_feed_goal = NEUTRAL_US;
                n_auto_on   = 1'b0;
            end else if (w_t < w_spin) begin
                n_fly_goal = FULL_FWD_US;
            end else if (w_t < w_total) begin
                n_feed_goal = speed_to_us(r_feed);
            end else begin
                n_fly_goal  = NEUTRAL_US;
                n_feed_goal = NEUTRAL_US;
                n_auto_on   = 1'b0;
            end
            // Count up, saturate at the top
            if (r_elapsed != TICK_MAX) begin
                n_elapsed = r_elapsed + TICK_W'(1);
            end
        end
    end

    // Ramp both channels toward the updated goals
    rps_ramp u_fly_ramp (
        .i_now  (r_fly_now),
        .i_goal (n_fly_goal),
        .i_step (r_ramp),
        .o_next (w_fly_ramp)
    );

    rps_ramp u_feed_ramp (
        .i_now  (r_feed_now),
        .i_goal (n_feed_goal),
        .i_step (r_ramp),
        .o_next (w_feed_ramp)
    );

    // Only ticks move the current widths
    assign n_fly_now  = w_tick ? w_fly_ramp  : r_fly_now;
    assign n_feed_now = w_tick ? w_feed_ramp : r_feed_now;

    // Load the result on accept, drop it once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_in_acc) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_up <= SPIN_UP_RST;
            r_shoot   <= SHOOT_RST;
            r_feed    <= FEED_RST;
            r_ramp    <= RAMP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SPIN_UP: r_spin_up <= i_cfg_data;
                CFG_SHOOT:   r_shoot   <= i_cfg_data;
                CFG_FEED:    r_feed    <= signed'(i_cfg_data[7:0]);
                CFG_RAMP:    r_ramp    <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Channel state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fly_goal  <= NEUTRAL_US;
            r_fly_now   <= NEUTRAL_US;
            r_feed_goal <= NEUTRAL_US;
            r_feed_now  <= NEUTRAL_US;
            r_auto_on   <= 1'b0;
            r_elapsed   <= '0;
            r_led_on    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fly_goal  <= n_fly_goal;
            r_fly_now   <= n_fly_now;
            r_feed_goal <= n_feed_goal;
            r_feed_now  <= n_feed_now;
            r_auto_on   <= n_auto_on;
            r_elapsed   <= n_elapsed;
            r_led_on    <= n_led_on;
            r_out_valid <= n_out_valid;
        end
    end

    // Result word mirrors the state after the accepted item
    assign o_out_valid         = r_out_valid;
    assign o_flywheel_pulse_us = r_fly_now;
    assign o_feeder_pulse_us   = r_feed_now;
    assign o_led_level         = r_led_on;
    assign o_auto_busy         = r_auto_on;

    // Checks
    `RPS_ASSERT_NEXT(a_shoot_starts, i_clk, i_rst_n, w_in_acc && (i_kind == KIND_CMD) && (i_command == CMD_SHOOT), o_auto_busy && (r_elapsed == '0))
    `RPS_ASSERT_NEXT(a_cancel_stops, i_clk, i_rst_n, w_in_acc && (i_kind == KIND_CMD) && (i_command == CMD_CANCEL), !o_auto_busy && (r_fly_goal == NEUTRAL_US) && (r_feed_goal == NEUTRAL_US))
    `RPS_ASSERT_NEXT(a_neutral_snap, i_clk, i_rst_n, w_tick && !r_auto_on && (r_fly_goal == NEUTRAL_US), o_out_valid && (o_flywheel_pulse_us == NEUTRAL_US))

endmodule

>>> hw/rtl/rps_ramp.sv
// ---------------------------------------------------------------------------
// rps_ramp
// One tick of slew-limited pulse width tracking toward a goal.
// ---------------------------------------------------------------------------
module rps_ramp (
    input  logic [rps_pkg::PULSE_W-1:0] i_now,
    input  logic [rps_pkg::PULSE_W-1:0] i_goal,
    input  logic [rps_pkg::STEP_W-1:0]  i_step,
    output logic [rps_pkg::PULSE_W-1:0] o_next
);
    import rps_pkg::*;

    logic [PULSE_W-1:0] w_step;
    logic [PULSE_W-1:0] w_up_diff;
    logic [PULSE_W-1:0] w_dn_diff;

    // Treat a zero step as one
    assign w_step    = (i_step == '0) ? PULSE_W'(1) : PULSE_W'(i_step);
    assign w_up_diff = i_goal - i_now;
    assign w_dn_diff = i_now - i_goal;

    // Snap to neutral, else move by at most one step without passing the goal
    always_comb begin
        priority if (i_goal == NEUTRAL_US) begin
            o_next = NEUTRAL_US;
        end else if (i_now < i_goal) begin
            o_next = (w_up_diff > w_step) ? (i_now + w_step) : i_goal;
        end else if (i_now > i_goal) begin
            o_next = (w_dn_diff > w_step) ? (i_now - w_step) : i_goal;
        end else begin
            o_next = i_now;
        end
    end

endmodule
